FILE: design/psaq_pkg.sv
// Package for the person sighting alarm qualifier.
// Holds field widths, register reset values, register indexes and shared types.
// No dependencies.
package psaq_pkg;

  localparam int PERSON_W       = 4;
  localparam int TIME_W         = 31;
  localparam int COUNT_W        = 16;
  localparam int PERSON_SPAN    = 1 << PERSON_W;
  localparam int MAX_PERSONS_DEF = 16;

  localparam int IN_TDATA_W  = 40;  // 4 + 31 bits, padded to bytes
  localparam int OUT_TDATA_W = 24;  // 1 + 4 + 16 bits, padded to bytes
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = TIME_W;

  localparam logic [COUNT_W-1:0] RST_THRESHOLD = 16'd5;
  localparam logic [TIME_W-1:0]  RST_WINDOW    = 31'd5;
  localparam logic [TIME_W-1:0]  RST_GAP       = 31'd10;
  localparam logic [TIME_W-1:0]  RST_INTERVAL  = 31'd20;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WINDOW    = 2'd1,
    CFG_GAP       = 2'd2,
    CFG_INTERVAL  = 2'd3
  } cfg_idx_t;

  // Per-person tracking entry
  typedef struct packed {
    logic [COUNT_W-1:0] sight_count;
    logic [TIME_W-1:0]  window_start;
    logic [TIME_W-1:0]  last_seen;
    logic [TIME_W-1:0]  last_alarm;
  } entry_t;

  // Configuration register set
  typedef struct packed {
    logic [COUNT_W-1:0] count_threshold;
    logic [TIME_W-1:0]  window_seconds;
    logic [TIME_W-1:0]  gap_seconds;
    logic [TIME_W-1:0]  alarm_interval_seconds;
  } cfg_t;

  // Outcome of evaluating one event
  typedef struct packed {
    logic               wr_en;
    entry_t             entry;
    logic               alarm;
    logic [COUNT_W-1:0] sighting_count;
  } update_t;

endpackage

FILE: design/psaq_table.sv
// Per-person state table of the alarm qualifier: one entry per tracked person.
// Cleared by reset, written at most once per event, read at one address.
// Depends on psaq_pkg.
module psaq_table #(
  parameter int DEPTH = psaq_pkg::MAX_PERSONS_DEF,
  parameter int IDX_W = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     idx,
  input  psaq_pkg::entry_t     wr_entry,
  output psaq_pkg::entry_t     rd_entry
);

  psaq_pkg::entry_t tbl_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        tbl_r[i] <= '0;
      end
    end else if (wr_en) begin
      tbl_r[idx] <= wr_entry;
    end
  end

  assign rd_entry = tbl_r[idx];

endmodule

FILE: design/psaq_rules.sv
// Rule evaluation for one recognition event against one person's entry.
// Pure combinational; signed time differences against the window, gap and interval.
// Depends on psaq_pkg.
module psaq_rules (
  input  psaq_pkg::entry_t                 cur,
  input  psaq_pkg::cfg_t                   cfg,
  input  logic                             in_range,
  input  logic                             recognized,
  input  logic [psaq_pkg::TIME_W-1:0]      frame_seconds,
  output psaq_pkg::update_t                upd
);

  localparam int DW = psaq_pkg::TIME_W + 2;

  logic signed [DW-1:0] d_win0, d_last0, d_alarm;
  logic signed [DW-1:0] win_s, gap_s, ivl_s;

  assign d_win0  = $signed({2'b00, frame_seconds}) - $signed({2'b00, cur.window_start});
  assign d_last0 = $signed({2'b00, frame_seconds}) - $signed({2'b00, cur.last_seen});
  assign d_alarm = $signed({2'b00, frame_seconds}) - $signed({2'b00, cur.last_alarm});
  assign win_s   = $signed({2'b00, cfg.window_seconds});
  assign gap_s   = $signed({2'b00, cfg.gap_seconds});
  assign ivl_s   = $signed({2'b00, cfg.alarm_interval_seconds});

  always_comb begin
    logic [psaq_pkg::COUNT_W-1:0] cnt;
    logic signed [DW-1:0]         dw;
    logic signed [DW-1:0]         dl;
    logic                         ws_now;
    logic                         ls_now;
    logic                         fire;

    cnt    = cur.sight_count;
    dw     = d_win0;
    dl     = d_last0;
    ws_now = 1'b0;
    ls_now = 1'b0;
    fire   = 1'b0;

    // first sighting: start the count
    if (cnt == '0) begin
      cnt = 16'd1; dw = '0; dl = '0; ws_now = 1'b1; ls_now = 1'b1;
    end
    // inside window and gap: extend, saturating
    if (cnt != '0 && dw < win_s && dl < gap_s) begin
      if (cnt != psaq_pkg::COUNT_MAX) cnt = cnt + 16'd1;
      dl = '0; ls_now = 1'b1;
    end
    // below threshold with stale window or long gap: restart
    if (cnt < cfg.count_threshold && (dw >= win_s || dl > gap_s)) begin
      cnt = 16'd1; dw = '0; dl = '0; ws_now = 1'b1; ls_now = 1'b1;
    end
    // at or above threshold but long gap: restart
    if (cnt >= cfg.count_threshold && dl > gap_s) begin
      cnt = 16'd1; dw = '0; dl = '0; ws_now = 1'b1; ls_now = 1'b1;
    end
    // qualify the alarm
    if (cnt >= cfg.count_threshold && dl < gap_s && dw >= win_s && d_alarm > ivl_s) begin
      fire = 1'b1; cnt = '0;
    end

    upd.wr_en              = in_range && recognized;
    upd.entry.sight_count  = cnt;
    upd.entry.window_start = ws_now ? frame_seconds : cur.window_start;
    upd.entry.last_seen    = ls_now ? frame_seconds : cur.last_seen;
    upd.entry.last_alarm   = fire ? frame_seconds : cur.last_alarm;
    upd.alarm              = in_range && recognized && fire;
    if (!in_range) begin
      upd.sighting_count = '0;
    end else if (recognized) begin
      upd.sighting_count = cnt;
    end else begin
      upd.sighting_count = cur.sight_count;
    end
  end

endmodule

FILE: design/person_sighting_alarm_qualifier.sv
// Top level of the person sighting alarm qualifier.
// Input register, state table, rule logic, result register and config registers.
// Depends on psaq_pkg, psaq_table, psaq_rules.

// One request on the input stream carries one recognition event (person index,
// recognized flag in tuser, frame time in seconds) and yields exactly one result
// request: alarm flag, echoed person and the person's sighting count after the
// event. An event enters the input register, is evaluated against its person's
// table entry in a single combinational pass, and lands in the result register
// while the entry is written back at the same edge, so a new event is taken
// every cycle while the result register can load. out_tvalid rises when the
// event moves from the input register into the result register. The
// next event always sees the entry left by the previous one. The result
// register lets the input keep flowing while a result waits for out_tready;
// the input stalls only when both registers hold undelivered requests. The
// table is cleared by reset. Write configuration only while idle.
module person_sighting_alarm_qualifier #(
  parameter int MAX_PERSONS = psaq_pkg::MAX_PERSONS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [psaq_pkg::IN_TDATA_W-1:0]    in_tdata,  // person_index[3:0], frame_seconds[34:4]
  input  logic                               in_tuser,  // recognized
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [psaq_pkg::OUT_TDATA_W-1:0]   out_tdata, // alarm[0], alarm_person[4:1],
                                                        // sighting_count[20:5]
  // configuration writes
  input  logic                               cfg_we,
  input  logic [psaq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psaq_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Only person indexes the input field can name need table entries.
  localparam int DEPTH = (MAX_PERSONS < psaq_pkg::PERSON_SPAN) ? MAX_PERSONS
                                                              : psaq_pkg::PERSON_SPAN;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int PW = psaq_pkg::PERSON_W;
  localparam int TW = psaq_pkg::TIME_W;
  localparam int CW = psaq_pkg::COUNT_W;

  // configuration registers
  psaq_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.count_threshold        <= psaq_pkg::RST_THRESHOLD;
      cfg_r.window_seconds         <= psaq_pkg::RST_WINDOW;
      cfg_r.gap_seconds            <= psaq_pkg::RST_GAP;
      cfg_r.alarm_interval_seconds <= psaq_pkg::RST_INTERVAL;
    end else if (cfg_we) begin
      case (psaq_pkg::cfg_idx_t'(cfg_index))
        psaq_pkg::CFG_THRESHOLD: cfg_r.count_threshold        <= cfg_data[CW-1:0];
        psaq_pkg::CFG_WINDOW:    cfg_r.window_seconds         <= cfg_data[TW-1:0];
        psaq_pkg::CFG_GAP:       cfg_r.gap_seconds            <= cfg_data[TW-1:0];
        psaq_pkg::CFG_INTERVAL:  cfg_r.alarm_interval_seconds <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic          s1_vld_r;
  logic [PW-1:0] s1_person_r;
  logic          s1_recog_r;
  logic [TW-1:0] s1_time_r;

  // result register
  logic          out_vld_r;
  logic          out_alarm_r;
  logic [PW-1:0] out_person_r;
  logic [CW-1:0] out_count_r;

  logic advance;   // result register free to load
  logic move;      // event leaves the input register this cycle

  assign advance   = !out_vld_r || out_tready;
  assign move      = s1_vld_r && advance;
  assign in_tready = !s1_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  // hold the payload while stalled
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_person_r <= in_tdata[PW-1:0];
      s1_time_r   <= in_tdata[PW+TW-1:PW];
      s1_recog_r  <= in_tuser;
    end
  end

  // table access and rule pass
  logic              in_range;
  logic [IDX_W-1:0]  tbl_idx;
  psaq_pkg::entry_t  cur_entry;
  psaq_pkg::update_t upd;

  assign in_range = int'(s1_person_r) < MAX_PERSONS;
  assign tbl_idx  = IDX_W'(s1_person_r);

  psaq_table #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (move && upd.wr_en),
    .idx      (tbl_idx),
    .wr_entry (upd.entry),
    .rd_entry (cur_entry)
  );

  psaq_rules u_rules (
    .cur           (cur_entry),
    .cfg           (cfg_r),
    .in_range      (in_range),
    .recognized    (s1_recog_r),
    .frame_seconds (s1_time_r),
    .upd           (upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_alarm_r  <= upd.alarm;
      out_person_r <= s1_person_r;
      out_count_r  <= upd.sighting_count;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(psaq_pkg::OUT_TDATA_W - 1 - PW - CW){1'b0}},
                       out_count_r, out_person_r, out_alarm_r};

endmodule
